### sv/alpe_pkg.sv
// alpe_pkg: shared constants and operation codes of the polyline evaluator
// no dependencies; used by alpe_mdiv, the top module and the bench
`default_nettype none
package alpe_pkg;

  localparam int unsigned LEN_W     = 40;  // arc length width, fixed point
  localparam int unsigned OUT_CW    = 20;  // coordinate port width
  localparam int unsigned CNT_OUT_W = 9;   // point count port width
  localparam int unsigned T_W       = 17;  // curve parameter width, Q1.16
  localparam logic [T_W-1:0] T_ONE  = 17'h10000;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_EVAL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

endpackage
`default_nettype wire

### sv/alpe_sqrt.sv
// alpe_sqrt: bit-serial integer square root, one result bit per cycle
// depends on no package items; NPAIR pairs of input plus FRAC fraction bits
`default_nettype none
module alpe_sqrt #(
  parameter int unsigned NPAIR = 21,
  parameter int unsigned FRAC  = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [2*NPAIR-1:0]       radicand,
  output logic                          done,
  output logic [NPAIR+FRAC-1:0]         root
);

  localparam int unsigned K  = NPAIR + FRAC;
  localparam int unsigned KW = $clog2(K + 1);

  logic [2*NPAIR-1:0] sh_r;
  logic [K+1:0]       rem_r;
  logic [K-1:0]       root_r;
  logic [KW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [K+1:0] rem_sh;
  logic [K+1:0] trial;

  always_comb begin
    rem_sh = {rem_r[K-1:0], sh_r[2*NPAIR-1 -: 2]};
    trial  = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sh_r   <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        // zeros shift in below the radicand for the fraction bits
        sh_r <= {sh_r[2*NPAIR-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[K-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[K-2:0], 1'b0};
        end
        if (cnt_r == KW'(K - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

### sv/alpe_mdiv.sv
// alpe_mdiv: serial shift-add multiply then restoring divide, floor(a*r/seg)
// needs r <= seg so the quotient fits in AW bits; uses alpe_pkg::LEN_W
`default_nettype none
module alpe_mdiv #(
  parameter int unsigned AW = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [AW-1:0]              a,
  input  wire logic [alpe_pkg::LEN_W-1:0] r,
  input  wire logic [alpe_pkg::LEN_W-1:0] seg,
  output logic                            done,
  output logic [AW-1:0]                   quot
);

  localparam int unsigned LW = alpe_pkg::LEN_W;
  localparam int unsigned CW = $clog2(AW + 1);

  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_MUL  = 3'b010,
    M_DIV  = 3'b100
  } mstate_t;

  mstate_t          state_r;
  logic [CW-1:0]    cnt_r;
  logic [AW-1:0]    a_r;
  logic [LW-1:0]    r_r;
  logic [LW-1:0]    seg_r;
  logic [AW+LW-1:0] acc_r;
  logic [LW:0]      rem_r;
  logic [AW-1:0]    q_r;
  logic             done_r;

  logic [LW:0] rem_sh;

  assign rem_sh = {rem_r[LW-1:0], q_r[AW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        M_IDLE: begin
          if (start) begin
            a_r     <= a;
            r_r     <= r;
            seg_r   <= seg;
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_MUL;
          end
        end
        M_MUL: begin
          acc_r <= (acc_r << 1) + (a_r[AW-1] ? (AW+LW)'(r_r) : '0);
          a_r   <= a_r << 1;
          if (cnt_r == CW'(AW - 1)) begin
            cnt_r   <= '0;
            state_r <= M_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        M_DIV: begin
          // first step loads the high part, which is below seg
          if (cnt_r == '0 && acc_r != '1) begin
            rem_r <= {1'b0, acc_r[AW +: LW]};
            q_r   <= acc_r[AW-1:0];
            acc_r <= '1;
          end else begin
            if (rem_sh >= {1'b0, seg_r}) begin
              rem_r <= rem_sh - {1'b0, seg_r};
              q_r   <= {q_r[AW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              q_r   <= {q_r[AW-2:0], 1'b0};
            end
            if (cnt_r == CW'(AW - 1)) begin
              done_r  <= 1'b1;
              state_r <= M_IDLE;
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
`default_nettype wire

### sv/arc_length_polyline_evaluator_top.sv
// arc_length_polyline_evaluator_top: polyline store, append and query control
// depends on alpe_pkg, alpe_sqrt, alpe_mdiv
//
//  channel | ports                                         | direction
//  input   | in_valid in_stall in_op in_x in_y in_z in_t_param | in
//  result  | out_valid out_stall out_x out_y out_z out_ok      | out
//          | out_total_length out_point_count                  |
//
// clear and failed operations go straight to the result step, the first point of a curve
// via S_SQ; any later append waits on the bit-serial square root, and a query on the
// serial multiply-divide per coordinate. one item is in work at a time.
// synchronous active-low reset empties the curve; the stores need no clearing.
// a stalled result holds the next item in its final step until the slot frees.
`default_nettype none
module arc_length_polyline_evaluator_top #(
  parameter int unsigned MAX_POINTS       = 256,
  parameter int unsigned COORD_BITS       = 20,
  parameter int unsigned LENGTH_FRAC_BITS = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          in_op,
  input  wire logic signed [alpe_pkg::OUT_CW-1:0]  in_x,
  input  wire logic signed [alpe_pkg::OUT_CW-1:0]  in_y,
  input  wire logic signed [alpe_pkg::OUT_CW-1:0]  in_z,
  input  wire logic [alpe_pkg::T_W-1:0]            in_t_param,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [alpe_pkg::OUT_CW-1:0]       out_x,
  output logic signed [alpe_pkg::OUT_CW-1:0]       out_y,
  output logic signed [alpe_pkg::OUT_CW-1:0]       out_z,
  output logic                                     out_ok,
  output logic [alpe_pkg::LEN_W-1:0]               out_total_length,
  output logic [alpe_pkg::CNT_OUT_W-1:0]           out_point_count
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned LW    = alpe_pkg::LEN_W;
  localparam int unsigned TW    = alpe_pkg::T_W;
  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned CW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW    = 3 * CB;
  localparam int unsigned NPAIR = CB + 1;
  localparam int unsigned D2W   = 2 * NPAIR;
  localparam int unsigned RW    = NPAIR + LENGTH_FRAC_BITS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_SQ    = 12'b000000000010,
    S_ROOT  = 12'b000000000100,
    S_SCALE = 12'b000000001000,
    S_SRCH  = 12'b000000010000,
    S_SCMP  = 12'b000000100000,
    S_F0    = 12'b000001000000,
    S_F1    = 12'b000010000000,
    S_F2    = 12'b000100000000,
    S_COORD = 12'b001000000000,
    S_CWAIT = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]        count_r;
  logic [LW-1:0]        sum_r;
  logic signed [CB-1:0] p_r [3];
  logic signed [CB-1:0] last_r [3];
  logic signed [CB-1:0] first_r [3];
  logic signed [CB-1:0] res_r [3];
  logic signed [CB-1:0] p0_r [3];
  logic signed [CB-1:0] p1_r [3];
  logic                 ok_r;
  logic [4:0]           cnt_r;
  logic [1:0]           ci_r;
  logic [2*CB-1:0]      sq_r;
  logic [D2W-1:0]       d2_r;
  logic [TW-1:0]        t_r;
  logic [LW+TW-1:0]     acc_r;
  logic [LW-1:0]        len_r;
  logic [AW-1:0]        lo_r;
  logic [AW-1:0]        hi_r;
  logic [LW-1:0]        c0_r;
  logic [LW-1:0]        seg_r;
  logic [LW-1:0]        rr_r;

  logic                 out_valid_r;
  logic signed [alpe_pkg::OUT_CW-1:0] ox_r, oy_r, oz_r;
  logic                 ook_r;
  logic [LW-1:0]        olen_r;
  logic [alpe_pkg::CNT_OUT_W-1:0] ocnt_r;

  // point and length stores
  logic [PW-1:0] pt_mem  [MAX_POINTS];
  logic [LW-1:0] cum_mem [MAX_POINTS];
  logic [PW-1:0] pt_rd_r;
  logic [LW-1:0] cum_rd_r;
  logic          we;
  logic [AW-1:0] wa;
  logic [LW-1:0] w_len;
  logic [AW-1:0] ra;

  logic          accept;
  logic          out_free;
  logic          full;
  logic [AW:0]   mid_sum;
  logic [AW-1:0] mid;

  logic signed [CB-1:0] sq_a, sq_b;
  logic signed [CB:0]   sq_d;
  logic [CB-1:0]        sq_m;

  logic signed [CB-1:0] c_p0, c_p1;
  logic signed [CB:0]   c_d;
  logic [CB-1:0]        c_m;

  logic          root_start, root_done;
  logic [RW-1:0] root;
  logic [LW:0]   sum_add;
  logic [LW-1:0] sum_new;

  logic          md_start, md_done;
  logic [CB-1:0] md_q;
  logic signed [CB:0] c_res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == CW'(MAX_POINTS));
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} + 1'b1;
  assign mid      = mid_sum[AW:1];

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin sq_a = p_r[0]; sq_b = last_r[0]; end
      2'd1:    begin sq_a = p_r[1]; sq_b = last_r[1]; end
      default: begin sq_a = p_r[2]; sq_b = last_r[2]; end
    endcase
    sq_d = (CB+1)'(sq_a) - (CB+1)'(sq_b);
    sq_m = sq_d[CB] ? CB'(-sq_d) : CB'(sq_d);

    case (ci_r)
      2'd0:    begin c_p0 = p0_r[0]; c_p1 = p1_r[0]; end
      2'd1:    begin c_p0 = p0_r[1]; c_p1 = p1_r[1]; end
      default: begin c_p0 = p0_r[2]; c_p1 = p1_r[2]; end
    endcase
    c_d   = (CB+1)'(c_p1) - (CB+1)'(c_p0);
    c_m   = c_d[CB] ? CB'(-c_d) : CB'(c_d);
    c_res = c_d[CB] ? (CB+1)'(c_p0) - (CB+1)'(md_q) : (CB+1)'(c_p0) + (CB+1)'(md_q);

    sum_add = {1'b0, sum_r} + (LW+1)'(root);
    sum_new = sum_add[LW] ? '1 : sum_add[LW-1:0];
  end

  // all three squares are in d2_r once cnt_r reaches 4
  assign root_start = (state_r == S_SQ) && (cnt_r == 5'd4);
  assign md_start   = (state_r == S_COORD) && (seg_r != '0);

  alpe_sqrt #(
    .NPAIR (NPAIR),
    .FRAC  (LENGTH_FRAC_BITS)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (d2_r),
    .done     (root_done),
    .root     (root)
  );

  alpe_mdiv #(
    .AW (CB)
  ) u_mdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (c_m),
    .r     (rr_r),
    .seg   (seg_r),
    .done  (md_done),
    .quot  (md_q)
  );

  // store write: first point straight from the input, later ones after the root
  always_comb begin
    we    = 1'b0;
    wa    = count_r[AW-1:0];
    w_len = sum_r;
    if (state_r == S_ROOT && root_done) begin
      we    = 1'b1;
      w_len = sum_new;
    end else if (state_r == S_SQ && count_r == '0) begin
      we    = 1'b1;
      w_len = '0;
    end
    case (state_r)
      S_SRCH:  ra = mid;
      S_F1:    ra = lo_r + 1'b1;
      default: ra = lo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      pt_mem[wa]  <= {p_r[2], p_r[1], p_r[0]};
      cum_mem[wa] <= w_len;
    end
    pt_rd_r  <= pt_mem[ra];
    cum_rd_r <= cum_mem[ra];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (alpe_pkg::op_t'(in_op))
            alpe_pkg::OP_APPEND: state_nxt = full ? S_OUT : S_SQ;
            alpe_pkg::OP_EVAL:
              state_nxt = (count_r >= CW'(2)) ? S_SCALE : S_OUT;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_SQ: begin
        if (count_r == '0)      state_nxt = S_OUT;
        else if (cnt_r == 5'd4) state_nxt = S_ROOT;
      end
      S_ROOT:  if (root_done) state_nxt = S_OUT;
      S_SCALE: if (cnt_r == 5'(TW - 1)) state_nxt = S_SRCH;
      S_SRCH:  state_nxt = (lo_r == hi_r) ? S_F0 : S_SCMP;
      S_SCMP:  state_nxt = S_SRCH;
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_COORD;
      S_COORD: if (seg_r == '0) state_nxt = (ci_r == 2'd2) ? S_OUT : S_COORD;
               else state_nxt = S_CWAIT;
      S_CWAIT: if (md_done) state_nxt = (ci_r == 2'd2) ? S_OUT : S_COORD;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)              out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          ci_r  <= '0;
          d2_r  <= '0;
          ok_r  <= 1'b0;
          for (int i = 0; i < 3; i++) res_r[i] <= '0;
          p_r[0] <= in_x[CB-1:0];
          p_r[1] <= in_y[CB-1:0];
          p_r[2] <= in_z[CB-1:0];
          t_r    <= (in_t_param > alpe_pkg::T_ONE) ? alpe_pkg::T_ONE : in_t_param;
          acc_r  <= '0;
          lo_r   <= '0;
          hi_r   <= AW'(count_r - CW'(2));
          if (accept) begin
            case (alpe_pkg::op_t'(in_op))
              alpe_pkg::OP_CLEAR: begin
                count_r <= '0;
                sum_r   <= '0;
                ok_r    <= 1'b1;
              end
              alpe_pkg::OP_EVAL: begin
                if (count_r == CW'(1)) begin
                  ok_r <= 1'b1;
                  for (int i = 0; i < 3; i++) res_r[i] <= first_r[i];
                end
              end
              default: ;
            endcase
          end
        end
        S_SQ: begin
          if (count_r == '0) begin
            // first point: no segment
            for (int i = 0; i < 3; i++) begin
              first_r[i] <= p_r[i];
              last_r[i]  <= p_r[i];
            end
            count_r <= count_r + 1'b1;
            ok_r    <= 1'b1;
          end else begin
            sq_r <= sq_m * sq_m;
            if (cnt_r inside {[5'd1:5'd3]}) d2_r <= d2_r + D2W'(sq_r);
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            sum_r   <= sum_new;
            count_r <= count_r + 1'b1;
            ok_r    <= 1'b1;
            for (int i = 0; i < 3; i++) last_r[i] <= p_r[i];
          end
        end
        S_SCALE: begin
          acc_r <= (acc_r << 1) + (t_r[TW-1] ? (LW+TW)'(sum_r) : '0);
          t_r   <= t_r << 1;
          cnt_r <= cnt_r + 1'b1;
        end
        S_SRCH: begin
          len_r <= acc_r[16 +: LW];
        end
        S_SCMP: begin
          if (cum_rd_r <= len_r) lo_r <= mid;
          else                   hi_r <= mid - 1'b1;
        end
        S_F1: begin
          c0_r    <= cum_rd_r;
          rr_r    <= len_r - cum_rd_r;
          p0_r[0] <= pt_rd_r[0 +: CB];
          p0_r[1] <= pt_rd_r[CB +: CB];
          p0_r[2] <= pt_rd_r[2*CB +: CB];
        end
        S_F2: begin
          seg_r   <= cum_rd_r - c0_r;
          if (rr_r > cum_rd_r - c0_r) rr_r <= cum_rd_r - c0_r;
          p1_r[0] <= pt_rd_r[0 +: CB];
          p1_r[1] <= pt_rd_r[CB +: CB];
          p1_r[2] <= pt_rd_r[2*CB +: CB];
        end
        S_COORD: begin
          if (seg_r == '0) begin
            res_r[ci_r] <= c_p0;
            ci_r        <= ci_r + 1'b1;
            if (ci_r == 2'd2) ok_r <= 1'b1;
          end
        end
        S_CWAIT: begin
          if (md_done) begin
            res_r[ci_r] <= c_res[CB-1:0];
            ci_r        <= ci_r + 1'b1;
            if (ci_r == 2'd2) ok_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            ox_r   <= alpe_pkg::OUT_CW'(res_r[0]);
            oy_r   <= alpe_pkg::OUT_CW'(res_r[1]);
            oz_r   <= alpe_pkg::OUT_CW'(res_r[2]);
            ook_r  <= ok_r;
            olen_r <= sum_r;
            ocnt_r <= alpe_pkg::CNT_OUT_W'(count_r);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_z            = oz_r;
  assign out_ok           = ook_r;
  assign out_total_length = olen_r;
  assign out_point_count  = ocnt_r;

endmodule
`default_nettype wire

### tb/tb_arc_length_polyline_evaluator_top.sv
// tb_arc_length_polyline_evaluator_top: self-checking bench for the polyline evaluator
// depends on alpe_pkg and arc_length_polyline_evaluator_top; a local model predicts each result
`timescale 1ns / 1ps
module tb_arc_length_polyline_evaluator_top;

  localparam int NPTS = 256;
  localparam int FRAC = 8;
  localparam logic [39:0] LEN_SAT = 40'hFF_FFFF_FFFF;
  localparam int WATCHDOG = 200000;
  localparam int N_RANDOM = 1065;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic               ok;
    logic [39:0]        total;
    logic [8:0]         count;
  } eval_result_t;

  typedef struct {
    alpe_pkg::op_t op;
    logic [19:0]   x, y, z;
    logic [16:0]   t;
    bit            has_expect;
    eval_result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = alpe_pkg::OP_CLEAR;
  logic signed [19:0] in_x = '0, in_y = '0, in_z = '0;
  logic [16:0] in_t_param = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [19:0] out_x, out_y, out_z;
  logic out_ok;
  logic [39:0] out_total_length;
  logic [8:0] out_point_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  arc_length_polyline_evaluator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_t_param(in_t_param),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_ok(out_ok),
    .out_total_length(out_total_length), .out_point_count(out_point_count)
  );

  // predictor state
  logic signed [19:0] pts [NPTS][3];
  logic [39:0] cum_len [NPTS];
  int unsigned npoints;
  logic [39:0] arc_total;

  eval_result_t pending_results[$];
  int errors;
  int n_results;
  int n_evals, n_fails;
  int idle_cycles;
  bit quiet_stretch;

  function automatic logic [63:0] seg_sqrt(logic [63:0] d2);
    logic [63:0] rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int k = 22 + FRAC - 1; k >= 0; k--) begin
      pair = (k >= FRAC) ? ((d2 >> (2 * (k - FRAC))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic eval_result_t predict_polyline(alpe_pkg::op_t op,
      logic signed [19:0] x, logic signed [19:0] y, logic signed [19:0] z,
      logic [16:0] tp);
    eval_result_t r;
    logic signed [63:0] p [3];
    logic signed [63:0] d, p0;
    logic [63:0] d2, seg, m, tt, target, rr, off;
    int unsigned i;
    r = '0;
    case (op)
      alpe_pkg::OP_CLEAR: begin
        npoints = 0;
        arc_total = '0;
        r.ok = 1'b1;
      end
      alpe_pkg::OP_APPEND: begin
        if (npoints < NPTS) begin
          p[0] = x; p[1] = y; p[2] = z;
          if (npoints > 0) begin
            d2 = 0;
            for (int c = 0; c < 3; c++) begin
              d = p[c] - 64'(pts[npoints-1][c]);
              m = d < 0 ? -d : d;
              d2 += m * m;
            end
            seg = seg_sqrt(d2);
            arc_total = (seg > 64'(LEN_SAT - arc_total)) ? LEN_SAT : arc_total + seg[39:0];
          end
          pts[npoints][0] = x; pts[npoints][1] = y; pts[npoints][2] = z;
          cum_len[npoints] = arc_total;
          npoints++;
          r.ok = 1'b1;
        end
      end
      alpe_pkg::OP_EVAL: begin
        if (npoints == 1) begin
          r.x = pts[0][0]; r.y = pts[0][1]; r.z = pts[0][2];
          r.ok = 1'b1;
        end else if (npoints >= 2) begin
          tt = (tp > alpe_pkg::T_ONE) ? 64'(alpe_pkg::T_ONE) : 64'(tp);
          target = (tt * 64'(arc_total)) >> 16;
          i = 0;
          for (int j = 0; j + 1 < npoints; j++)
            if (64'(cum_len[j]) <= target) i = j;
          rr = target - 64'(cum_len[i]);
          seg = 64'(cum_len[i+1]) - 64'(cum_len[i]);
          for (int c = 0; c < 3; c++) begin
            p0 = pts[i][c];
            d = 64'(pts[i+1][c]) - p0;
            off = 0;
            if (seg != 0) begin
              if (rr > seg) rr = seg;
              m = d < 0 ? -d : d;
              off = (m * rr) / seg;
            end
            p[c] = d < 0 ? p0 - $signed(off) : p0 + $signed(off);
          end
          r.x = p[0][19:0]; r.y = p[1][19:0]; r.z = p[2][19:0];
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.total = arc_total;
    r.count = 9'(npoints);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
    errors++;
  endtask

  // result side: random stall, compare each transfer with oldest prediction
  always @(posedge clk) begin
    eval_result_t w;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected transfer", 64'(out_ok), 64'd0);
        end else begin
          w = pending_results.pop_front();
          if (out_x !== w.x) report_mismatch("x", 64'(out_x), 64'(w.x));
          if (out_y !== w.y) report_mismatch("y", 64'(out_y), 64'(w.y));
          if (out_z !== w.z) report_mismatch("z", 64'(out_z), 64'(w.z));
          if (out_ok !== w.ok) report_mismatch("ok", 64'(out_ok), 64'(w.ok));
          if (out_total_length !== w.total)
            report_mismatch("total_length", 64'(out_total_length), 64'(w.total));
          if (out_point_count !== w.count)
            report_mismatch("point_count", 64'(out_point_count), 64'(w.count));
        end
        n_results++;
      end
      out_stall <= !quiet_stretch && ($urandom_range(99) < 15);
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // present one item and hold it until the transfer
  task automatic send_item(alpe_pkg::op_t op, logic [19:0] x, logic [19:0] y,
      logic [19:0] z, logic [16:0] t, bit has_expect, eval_result_t want);
    eval_result_t pred;
    while (!quiet_stretch && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op; in_x <= x; in_y <= y; in_z <= z; in_t_param <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_polyline(op, x, y, z, t);
    if (op == alpe_pkg::OP_EVAL) begin
      n_evals++;
      if (!pred.ok) n_fails++;
    end
    if (has_expect && pred !== want) begin
      $display("directed row disagrees with predictor, op %s", op.name());
      errors++;
    end
    pending_results.push_back(pred);
  endtask

  function automatic logic [19:0] rand_coord(int mode);
    case (mode)
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'($signed($urandom_range(200)) - 100);
      default: return 20'($urandom);
    endcase
  endfunction

  stim_row_t rows[$];

  function automatic stim_row_t mk(alpe_pkg::op_t op, logic [19:0] x, logic [19:0] y,
      logic [19:0] z, logic [16:0] t, bit he, eval_result_t w);
    stim_row_t s;
    s.op = op; s.x = x; s.y = y; s.z = z; s.t = t; s.has_expect = he; s.want = w;
    return s;
  endfunction

  initial begin
    eval_result_t e;
    stim_row_t s;
    alpe_pkg::op_t op;
    int mode, burst;
    errors = 0; n_results = 0; n_evals = 0; n_fails = 0;
    npoints = 0; arc_total = '0; quiet_stretch = 1'b0;
    for (int i = 0; i < NPTS; i++) begin
      cum_len[i] = '0;
      for (int c = 0; c < 3; c++) pts[i][c] = '0;
    end

    // directed table: empty query, unknown op, extremes, zero segment, clamp
    e = '0;
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h8000, 1, e));
    rows.push_back(mk(alpe_pkg::OP_NONE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 17'h1FFFF, 1, e));
    e = '0; e.ok = 1; e.count = 1;
    rows.push_back(mk(alpe_pkg::OP_APPEND, 20'h7FFFF, 20'h80000, 20'h7FFFF, 0, 1, e));
    e.x = 20'h7FFFF; e.y = 20'h80000; e.z = 20'h7FFFF;
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h1FFFF, 1, e));
    rows.push_back(mk(alpe_pkg::OP_APPEND, 20'h80000, 20'h7FFFF, 20'h80000, 0, 0, e));
    rows.push_back(mk(alpe_pkg::OP_APPEND, 20'h80000, 20'h7FFFF, 20'h80000, 0, 0, e));
    rows.push_back(mk(alpe_pkg::OP_APPEND, 20'h0, 20'h0, 20'h0, 0, 0, e));
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h0, 0, e));
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h0AAAA, 0, e));
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h10000, 0, e));
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h1FFFF, 0, e));
    e = '0; e.ok = 1;
    rows.push_back(mk(alpe_pkg::OP_CLEAR, 20'hFFFFF, 0, 0, 17'h1FFFF, 1, e));
    rows.push_back(mk(alpe_pkg::OP_APPEND, 20'h3, 20'h4, 20'h0, 0, 0, e));
    rows.push_back(mk(alpe_pkg::OP_APPEND, 20'h3, 20'h4, 20'h0, 0, 0, e));
    rows.push_back(mk(alpe_pkg::OP_APPEND, 20'hFFFFD, 20'hFFFFC, 20'h5, 0, 0, e));
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h5555, 0, e));
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'h1, 0, e));
    rows.push_back(mk(alpe_pkg::OP_EVAL, 0, 0, 0, 17'hFFFF, 0, e));

    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      s = rows[i];
      send_item(s.op, s.x, s.y, s.z, s.t, s.has_expect, s.want);
    end

    // fill the store to capacity, then overflow it
    quiet_stretch = 1'b1;
    send_item(alpe_pkg::OP_CLEAR, 0, 0, 0, 0, 0, e);
    for (int i = 0; i < NPTS + 2; i++)
      send_item(alpe_pkg::OP_APPEND, rand_coord(i % 4), rand_coord(3), rand_coord(2),
                0, 0, e);
    quiet_stretch = 1'b0;
    for (int i = 0; i < 6; i++)
      send_item(alpe_pkg::OP_EVAL, 0, 0, 0, 17'($urandom), 0, e);

    // sender holds off until the result side drains
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // random curves: mostly short builds followed by queries, some noise
    for (int n = 0; n < N_RANDOM; ) begin
      if ($urandom_range(9) == 0) begin
        op = alpe_pkg::op_t'($urandom_range(3));
        send_item(op, 20'($urandom), 20'($urandom), 20'($urandom), 17'($urandom), 0, e);
        n++;
      end else begin
        send_item(alpe_pkg::OP_CLEAR, 0, 0, 0, 0, 0, e);
        mode = $urandom_range(3);
        burst = $urandom_range(1, 8);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(7) == 0 && npoints > 0)
            send_item(alpe_pkg::OP_APPEND, pts[npoints-1][0], pts[npoints-1][1],
                      pts[npoints-1][2], 0, 0, e);
          else
            send_item(alpe_pkg::OP_APPEND, rand_coord(mode), rand_coord(mode),
                      rand_coord($urandom_range(3)), 0, 0, e);
        end
        for (int k = 0; k < 4; k++)
          send_item(alpe_pkg::OP_EVAL, 20'($urandom), 20'($urandom), 20'($urandom),
                    $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(65536)),
                    0, e);
        n += burst + 5;
      end
      if (n > 500 && n < 700) quiet_stretch = 1'b1;
      else quiet_stretch = 1'b0;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("covered %0d results: %0d queries, %0d on empty curves, full-store overflow",
             n_results, n_evals, n_fails);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
